/* rtl/srv_pkg.sv */
// ----------------------------------------------------------------------------
// srv_pkg
// Shared types and constants for the settings record validator.
// ----------------------------------------------------------------------------
package srv_pkg;

    localparam int unsigned SepIdLenDefault = 32;

    localparam logic [7:0]  RecLen          = 8'd220;
    localparam logic [7:0]  CrcEnd          = 8'd216;
    localparam logic [7:0]  IdStart         = 8'd16;
    localparam logic [7:0]  PosPreview      = 8'd152;
    localparam logic [7:0]  PosXpad         = 8'd153;
    localparam logic [31:0] RecMagic        = 32'h5344_4f4d;
    localparam logic [31:0] CrcPoly         = 32'hedb8_8320;
    localparam logic [31:0] AllOnes         = 32'hffff_ffff;
    localparam logic [15:0] RecVersion      = 16'd1;
    localparam logic [7:0]  ThemeCountReset = 8'd8;
    localparam logic [5:0]  IdLenMax        = 6'd63;

    typedef enum logic [2:0] {
        ST_VALID    = 3'd0,
        ST_SHORT    = 3'd1,
        ST_HDR_BAD  = 3'd2,
        ST_VER_BAD  = 3'd3,
        ST_CRC_BAD  = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] record_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        t_status    status;
        logic       gate_on;
        logic       smart_on;
        logic       preview_on;
        logic       stems_on;
        logic       xpad_on;
        logic       stem_manual_on;
        logic [7:0] theme_index;
        logic       sep_id_ok;
    } t_out;

    // Reflected CRC-32, one byte folded in bit by bit.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic id_char_ok(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) ||
               (b >= 8'h30 && b <= 8'h39) || b == 8'h2d || b == 8'h2e || b == 8'h5f;
    endfunction

endpackage

/* rtl/srv_ident_check.sv */
// ----------------------------------------------------------------------------
// srv_ident_check
// Tracks the identifier field of the record and reports whether it is valid.
// ----------------------------------------------------------------------------
module srv_ident_check #(
    parameter int unsigned SEP_ID_LEN = srv_pkg::SepIdLenDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic       i_clear,
    input  logic [7:0] i_pos,
    input  logic [7:0] i_byte,
    output logic       o_id_ok
);

    // The last byte of the field acts as a terminator and is not examined.
    localparam logic [8:0] IdEnd = 9'(int'(srv_pkg::IdStart) + SEP_ID_LEN - 1);

    logic [5:0] r_len,   n_len;
    logic       r_ended, n_ended;
    logic       r_bad,   n_bad;
    logic       r_dot0,  n_dot0;
    logic       r_dot1,  n_dot1;
    logic       in_field;
    logic       is_dot;

    assign in_field = ({1'b0, i_pos} >= {1'b0, srv_pkg::IdStart}) && ({1'b0, i_pos} < IdEnd);
    assign is_dot   = (i_byte == 8'h2e);

    always_comb begin
        n_len   = r_len;
        n_ended = r_ended;
        n_bad   = r_bad;
        n_dot0  = r_dot0;
        n_dot1  = r_dot1;
        if (i_clear) begin
            n_len   = '0;
            n_ended = 1'b0;
            n_bad   = 1'b0;
            n_dot0  = 1'b0;
            n_dot1  = 1'b0;
        end else if (i_take && in_field && !r_ended) begin
            if (i_byte == 8'd0) begin
                n_ended = 1'b1;
            end else begin
                if (!srv_pkg::id_char_ok(i_byte)) begin
                    n_bad = 1'b1;
                end
                if (i_pos == srv_pkg::IdStart && is_dot) begin
                    n_dot0 = 1'b1;
                end
                if (i_pos == srv_pkg::IdStart + 8'd1 && is_dot) begin
                    n_dot1 = 1'b1;
                end
                if (r_len < srv_pkg::IdLenMax) begin
                    n_len = r_len + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_ended <= 1'b0;
            r_bad   <= 1'b0;
            r_dot0  <= 1'b0;
            r_dot1  <= 1'b0;
        end else begin
            r_len   <= n_len;
            r_ended <= n_ended;
            r_bad   <= n_bad;
            r_dot0  <= n_dot0;
            r_dot1  <= n_dot1;
        end
    end

    // A lone "." or ".." is rejected.
    assign o_id_ok = !r_bad && (r_len != 6'd0) &&
                     !(r_dot0 && (r_len == 6'd1 || (r_len == 6'd2 && r_dot1)));

endmodule

/* rtl/settings_record_validator.sv */
// ----------------------------------------------------------------------------
// settings_record_validator
// Parses a 220-byte settings record one byte per beat, checks its header and
// CRC-32, and gives one verdict beat for each beat flagged as last.
// ----------------------------------------------------------------------------
// Throughput: one input beat per clock (set by the byte-wide CRC update) unless stalled.
// The verdict enters the result register on the clock edge that accepts the last beat.
// A pending verdict stalls only an incoming last beat; other beats keep flowing.
// Reset (synchronous, active low) clears the record state, sets theme_count
// to 8 and empties the result register.
module settings_record_validator #(
    parameter int unsigned SEP_ID_LEN = srv_pkg::SepIdLenDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  srv_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output srv_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_data
);

    logic [7:0]  r_theme_count;
    logic [7:0]  r_pos,     n_pos;
    logic [31:0] r_crc,     n_crc;
    logic [31:0] r_magic,   n_magic;
    logic [15:0] r_version, n_version;
    logic [15:0] r_size,    n_size;
    logic [5:0]  r_flags,   n_flags;
    logic [31:0] r_theme,   n_theme;
    logic [31:0] r_stored,  n_stored;

    logic          r_out_valid, n_out_valid;
    srv_pkg::t_out r_out,       n_out;

    logic       in_fire;
    logic       take;
    logic       clear;
    logic       id_ok;
    logic [7:0] b;
    logic       ok;
    srv_pkg::t_status status;

    assign b          = i_in_data.record_byte;
    assign o_in_ready = !(r_out_valid && !i_out_ready && i_in_data.last_byte);
    assign in_fire    = i_in_valid && o_in_ready;
    assign take       = in_fire && (r_pos < srv_pkg::RecLen);
    assign clear      = in_fire && i_in_data.last_byte;
    assign o_cfg_ready = 1'b1;

    srv_ident_check #(
        .SEP_ID_LEN (SEP_ID_LEN)
    ) u_ident (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_clear (clear),
        .i_pos   (r_pos),
        .i_byte  (b),
        .o_id_ok (id_ok)
    );

    // Field capture for the current byte.
    always_comb begin
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_magic   = r_magic;
        n_version = r_version;
        n_size    = r_size;
        n_flags   = r_flags;
        n_theme   = r_theme;
        n_stored  = r_stored;
        if (take) begin
            n_pos = r_pos + 8'd1;
            if (r_pos < srv_pkg::CrcEnd) begin
                n_crc = srv_pkg::crc_byte(r_crc, b);
            end
            if (r_pos < 8'd4) begin
                n_magic[{r_pos[1:0], 3'b000} +: 8] = b;
            end else if (r_pos < 8'd6) begin
                n_version[{r_pos[0], 3'b000} +: 8] = b;
            end else if (r_pos < 8'd8) begin
                n_size[{r_pos[0], 3'b000} +: 8] = b;
            end else if (r_pos < 8'd12) begin
                if (b != 8'd0) begin
                    n_flags[r_pos[1:0]] = 1'b1;
                end
            end else if (r_pos < 8'd16) begin
                n_theme[{r_pos[1:0], 3'b000} +: 8] = b;
            end else if (r_pos >= srv_pkg::CrcEnd) begin
                n_stored[{r_pos[1:0], 3'b000} +: 8] = b;
            end
            if (r_pos == srv_pkg::PosPreview && b != 8'd0) begin
                n_flags[4] = 1'b1;
            end
            if (r_pos == srv_pkg::PosXpad && b != 8'd0) begin
                n_flags[5] = 1'b1;
            end
        end
    end

    // Verdict. A full record means the CRC bytes were all folded in before
    // this beat, so the running CRC register is already final.
    always_comb begin
        if (n_pos < srv_pkg::RecLen) begin
            status = srv_pkg::ST_SHORT;
        end else if (r_magic != srv_pkg::RecMagic || r_size != {8'd0, srv_pkg::RecLen}) begin
            status = srv_pkg::ST_HDR_BAD;
        end else if (r_version != srv_pkg::RecVersion) begin
            status = srv_pkg::ST_VER_BAD;
        end else if ((r_crc ^ srv_pkg::AllOnes) != n_stored) begin
            status = srv_pkg::ST_CRC_BAD;
        end else begin
            status = srv_pkg::ST_VALID;
        end
        ok = (status == srv_pkg::ST_VALID);

        n_out.status         = status;
        n_out.gate_on        = ok && r_flags[0];
        n_out.stems_on       = ok && r_flags[1];
        n_out.stem_manual_on = ok && r_flags[2];
        n_out.smart_on       = ok && r_flags[3];
        n_out.preview_on     = ok && !r_flags[4];
        n_out.xpad_on        = ok && r_flags[5];
        n_out.theme_index    = (ok && r_theme < {24'd0, r_theme_count}) ? r_theme[7:0] : 8'd0;
        n_out.sep_id_ok      = ok && id_ok;

        n_out_valid = r_out_valid;
        if (clear) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theme_count <= srv_pkg::ThemeCountReset;
            r_pos         <= '0;
            r_crc         <= srv_pkg::AllOnes;
            r_magic       <= '0;
            r_version     <= '0;
            r_size        <= '0;
            r_flags       <= '0;
            r_theme       <= '0;
            r_stored      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_theme_count <= i_cfg_data;
            end
            r_out_valid <= n_out_valid;
            if (clear) begin
                r_pos     <= '0;
                r_crc     <= srv_pkg::AllOnes;
                r_magic   <= '0;
                r_version <= '0;
                r_size    <= '0;
                r_flags   <= '0;
                r_theme   <= '0;
                r_stored  <= '0;
            end else begin
                r_pos     <= n_pos;
                r_crc     <= n_crc;
                r_magic   <= n_magic;
                r_version <= n_version;
                r_size    <= n_size;
                r_flags   <= n_flags;
                r_theme   <= n_theme;
                r_stored  <= n_stored;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (clear) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* bench/srv_checker.sv */
// ----------------------------------------------------------------------------
// srv_checker
// Watches the record, verdict and register channels of the settings record
// validator. It keeps its own copy of the parse state, works out the verdict
// of each record when its last beat is accepted, and compares every accepted
// verdict beat field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module srv_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  srv_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  srv_pkg::t_out i_out_data,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic [7:0]    i_cfg_data,
    output int            o_mismatches,
    output int            o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    // Only the first SEP_ID_LEN-1 identifier bytes are examined.
    localparam int NameSpan = srv_pkg::SepIdLenDefault - 1;
    localparam logic [7:0] Dot = 8'h2e;

    logic [7:0]    theme_limit = srv_pkg::ThemeCountReset;
    logic [7:0]    pos         = '0;
    logic [31:0]   crc_acc     = srv_pkg::AllOnes;
    logic [31:0]   magic_acc   = '0;
    logic [15:0]   ver_acc     = '0;
    logic [15:0]   size_acc    = '0;
    logic [5:0]    flag_acc    = '0;
    logic [31:0]   theme_acc   = '0;
    logic [31:0]   crc_seen    = '0;
    int            name_len    = 0;
    logic          name_ended  = 1'b0;
    logic          name_bad    = 1'b0;
    logic          name_dot0   = 1'b0;
    logic          name_dot1   = 1'b0;
    int            mismatches  = 0;
    srv_pkg::t_out verdict_q[$];

    // Bit-serial form: each data bit is compared with the low CRC bit.
    function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ b[i]) begin
                r = (r >> 1) ^ srv_pkg::CrcPoly;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic name_char_ok(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h61 && c <= 8'h7a) || c == 8'h2d || c == Dot || c == 8'h5f;
    endfunction

    task automatic restart_record();
        pos        = '0;
        crc_acc    = srv_pkg::AllOnes;
        magic_acc  = '0;
        ver_acc    = '0;
        size_acc   = '0;
        flag_acc   = '0;
        theme_acc  = '0;
        crc_seen   = '0;
        name_len   = 0;
        name_ended = 1'b0;
        name_bad   = 1'b0;
        name_dot0  = 1'b0;
        name_dot1  = 1'b0;
    endtask

    task automatic absorb(input logic [7:0] b);
        if (pos < srv_pkg::CrcEnd) begin
            crc_acc = crc_fold(crc_acc, b);
        end
        if (pos < 8'd4) begin
            magic_acc[pos[1:0]*8 +: 8] = b;
        end else if (pos < 8'd6) begin
            ver_acc[pos[0]*8 +: 8] = b;
        end else if (pos < 8'd8) begin
            size_acc[pos[0]*8 +: 8] = b;
        end else if (pos < 8'd12) begin
            if (b != 8'd0) flag_acc[pos - 8'd8] = 1'b1;
        end else if (pos < 8'd16) begin
            theme_acc[pos[1:0]*8 +: 8] = b;
        end else if (pos >= srv_pkg::CrcEnd) begin
            crc_seen[pos[1:0]*8 +: 8] = b;
        end
        if (pos == srv_pkg::PosPreview && b != 8'd0) flag_acc[4] = 1'b1;
        if (pos == srv_pkg::PosXpad && b != 8'd0) flag_acc[5] = 1'b1;

        // The identifier stops at its first zero byte.
        if (pos >= srv_pkg::IdStart && pos < srv_pkg::IdStart + NameSpan && !name_ended) begin
            if (b == 8'd0) begin
                name_ended = 1'b1;
            end else begin
                if (!name_char_ok(b)) name_bad = 1'b1;
                if (pos == srv_pkg::IdStart && b == Dot) name_dot0 = 1'b1;
                if (pos == srv_pkg::IdStart + 1 && b == Dot) name_dot1 = 1'b1;
                name_len++;
            end
        end
        pos = pos + 8'd1;
    endtask

    function automatic srv_pkg::t_out record_verdict();
        srv_pkg::t_out v;
        logic name_ok;
        v = '0;
        if (pos < srv_pkg::RecLen) begin
            v.status = srv_pkg::ST_SHORT;
        end else if (magic_acc != srv_pkg::RecMagic || size_acc != {8'd0, srv_pkg::RecLen}) begin
            v.status = srv_pkg::ST_HDR_BAD;
        end else if (ver_acc != srv_pkg::RecVersion) begin
            v.status = srv_pkg::ST_VER_BAD;
        end else if (~crc_acc != crc_seen) begin
            v.status = srv_pkg::ST_CRC_BAD;
        end else begin
            // A lone dot or a double dot is not a usable name.
            name_ok = !name_bad && name_len > 0 &&
                      !(name_dot0 && (name_len == 1 || (name_len == 2 && name_dot1)));
            v.status         = srv_pkg::ST_VALID;
            v.gate_on        = flag_acc[0];
            v.stems_on       = flag_acc[1];
            v.stem_manual_on = flag_acc[2];
            v.smart_on       = flag_acc[3];
            v.preview_on     = ~flag_acc[4];
            v.xpad_on        = flag_acc[5];
            v.theme_index    = (theme_acc < {24'd0, theme_limit}) ? theme_acc[7:0] : 8'd0;
            v.sep_id_ok      = name_ok;
        end
        return v;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic compare_verdict(input srv_pkg::t_out got);
        srv_pkg::t_out want;
        if (verdict_q.size() == 0) begin
            mismatches++;
            $display("%0t: verdict beat with none expected, expected none actual %h",
                     $time, got);
        end else begin
            want = verdict_q.pop_front();
            check_field("status", 8'(want.status), 8'(got.status));
            check_field("gate_on", 8'(want.gate_on), 8'(got.gate_on));
            check_field("smart_on", 8'(want.smart_on), 8'(got.smart_on));
            check_field("preview_on", 8'(want.preview_on), 8'(got.preview_on));
            check_field("stems_on", 8'(want.stems_on), 8'(got.stems_on));
            check_field("xpad_on", 8'(want.xpad_on), 8'(got.xpad_on));
            check_field("stem_manual_on", 8'(want.stem_manual_on), 8'(got.stem_manual_on));
            check_field("theme_index", want.theme_index, got.theme_index);
            check_field("sep_id_ok", 8'(want.sep_id_ok), 8'(got.sep_id_ok));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            theme_limit = srv_pkg::ThemeCountReset;
            restart_record();
            verdict_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) theme_limit = i_cfg_data;
            if (i_out_valid && i_out_ready) compare_verdict(i_out_data);
            if (i_in_valid && i_in_ready) begin
                // Bytes past the end of the record are dropped.
                if (pos < srv_pkg::RecLen) absorb(i_in_data.record_byte);
                if (i_in_data.last_byte) begin
                    verdict_q.push_back(record_verdict());
                    restart_record();
                end
            end
        end
        o_mismatches <= mismatches;
        o_waiting    <= verdict_q.size();
    end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Feeds settings records to the validator a byte per beat: a full record with
// every flag on, a one-beat record, an overlong record at the widest
// theme_count, then short random records, the later ones with random gaps on
// both channels and one long verdict hold-off. The checker beside the block
// predicts and compares every verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RecBytes   = int'(srv_pkg::RecLen);
    localparam int StallLimit = 3000;
    localparam int HoldCycles = 400;
    localparam logic [7:0] Dot = 8'h2e;

    typedef enum int {
        NAME_PLAIN, NAME_FULL, NAME_EMPTY, NAME_DOT, NAME_DOTDOT, NAME_DOTTED, NAME_STRAY
    } t_name_kind;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    srv_pkg::t_in  in_data   = '0;
    logic          in_ready;
    logic          out_valid;
    logic          out_ready = 1'b0;
    srv_pkg::t_out out_data;
    logic          cfg_valid = 1'b0;
    logic [7:0]    cfg_data  = '0;
    logic          cfg_ready;
    int            mismatches;
    int            waiting;

    logic       no_gaps      = 1'b0;
    logic       hold_kick    = 1'b0;
    logic       hold_seen    = 1'b0;
    int         hold_left    = 0;
    int         quiet_cycles = 0;
    logic [7:0] theme_now    = srv_pkg::ThemeCountReset;
    logic [7:0] rec [RecBytes];

    settings_record_validator uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    srv_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_waiting    (waiting)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Verdict side: random stalls, and a long hold-off each time hold_kick flips.
    always @(posedge clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HoldCycles;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= no_gaps || ($urandom_range(99) >= 28);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= StallLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] name_char();
        case ($urandom_range(3))
            0: return 8'h41 + 8'($urandom_range(25));
            1: return 8'h61 + 8'($urandom_range(25));
            2: return 8'h30 + 8'($urandom_range(9));
            default: begin
                case ($urandom_range(2))
                    0: return 8'h2d;
                    1: return Dot;
                    default: return 8'h5f;
                endcase
            end
        endcase
    endfunction

    // Nonzero bytes outside the allowed identifier set.
    function automatic logic [7:0] stray_char();
        case ($urandom_range(4))
            0: return 8'($urandom_range(44, 1));
            1: return 8'($urandom_range(255, 123));
            2: return 8'h3a + 8'($urandom_range(6));
            3: return 8'h5b + 8'($urandom_range(3));
            default: return ($urandom_range(1) != 0) ? 8'h2f : 8'h60;
        endcase
    endfunction

    function automatic logic [7:0] maybe_on();
        return ($urandom_range(1) != 0) ? 8'($urandom_range(255, 1)) : 8'h00;
    endfunction

    function automatic logic [31:0] pick_theme();
        case ($urandom_range(4))
            0: return 32'($urandom_range(255));
            1: return {24'd0, theme_now};
            2: return $urandom;
            3: return 32'($urandom_range(int'(theme_now)));
            default: return {16'd0, 8'($urandom_range(3)), 8'($urandom_range(255))};
        endcase
    endfunction

    function automatic t_name_kind pick_name();
        if ($urandom_range(99) < 50) return NAME_PLAIN;
        return t_name_kind'($urandom_range(int'(NAME_STRAY)));
    endfunction

    task automatic fill_name(input t_name_kind kind);
        int n;
        for (int i = 16; i < 48; i++) rec[i] = 8'($urandom);
        case (kind)
            NAME_PLAIN: begin
                n = $urandom_range(30, 1);
                for (int i = 0; i < n; i++) rec[16 + i] = name_char();
                rec[16 + n] = 8'h00;
            end
            NAME_FULL: begin
                // No terminator: the last identifier byte is never looked at.
                for (int i = 0; i < 31; i++) rec[16 + i] = name_char();
            end
            NAME_EMPTY: rec[16] = 8'h00;
            NAME_DOT: begin
                rec[16] = Dot;
                rec[17] = 8'h00;
            end
            NAME_DOTDOT: begin
                rec[16] = Dot;
                rec[17] = Dot;
                rec[18] = 8'h00;
            end
            NAME_DOTTED: begin
                n = $urandom_range(30, 2);
                rec[16] = Dot;
                for (int i = 1; i < n; i++) rec[16 + i] = name_char();
                if ($urandom_range(1) != 0) rec[17] = Dot;
                rec[16 + n] = 8'h00;
            end
            default: begin
                n = $urandom_range(30, 1);
                for (int i = 0; i < n; i++) rec[16 + i] = name_char();
                rec[16 + $urandom_range(n - 1)] = stray_char();
                rec[16 + n] = 8'h00;
            end
        endcase
    endtask

    // A well-formed record apart from its CRC, which seal_crc adds.
    task automatic build_record(input logic [31:0] theme, input t_name_kind kind);
        for (int i = 0; i < RecBytes; i++) rec[i] = 8'($urandom);
        {rec[3], rec[2], rec[1], rec[0]} = srv_pkg::RecMagic;
        {rec[5], rec[4]} = srv_pkg::RecVersion;
        {rec[7], rec[6]} = {8'd0, srv_pkg::RecLen};
        for (int i = 8; i < 12; i++) rec[i] = maybe_on();
        {rec[15], rec[14], rec[13], rec[12]} = theme;
        fill_name(kind);
        rec[srv_pkg::PosPreview] = maybe_on();
        rec[srv_pkg::PosXpad] = maybe_on();
    endtask

    task automatic seal_crc();
        logic [31:0] c;
        c = srv_pkg::AllOnes;
        for (int i = 0; i < int'(srv_pkg::CrcEnd); i++) begin
            for (int k = 0; k < 8; k++) begin
                c = (c >> 1) ^ ((c[0] ^ rec[i][k]) ? srv_pkg::CrcPoly : 32'd0);
            end
        end
        {rec[219], rec[218], rec[217], rec[216]} = ~c;
    endtask

    task automatic send_beat(input logic [7:0] b, input logic last);
        srv_pkg::t_in beat;
        beat.record_byte = b;
        beat.last_byte   = last;
        if (!no_gaps && $urandom_range(99) < 28) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_record(input int n);
        for (int i = 0; i < n; i++) begin
            send_beat((i < RecBytes) ? rec[i] : 8'($urandom), i == n - 1);
        end
    endtask

    // A random record cut off after at most max_len beats.
    task automatic random_short_record(input int max_len);
        build_record(pick_theme(), pick_name());
        seal_crc();
        send_record($urandom_range(max_len, 1));
    endtask

    // Waits until every verdict is in and the block has settled.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_theme_count(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        theme_now = v;
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every flag on, theme just under the limit, longest identifier.
        build_record(32'd7, NAME_FULL);
        for (int i = 8; i < 12; i++) rec[i] = 8'hff;
        rec[srv_pkg::PosPreview] = 8'h00;
        rec[srv_pkg::PosXpad] = 8'h80;
        seal_crc();
        send_record(RecBytes);

        // A record of one beat is short.
        send_beat(8'hff, 1'b1);

        // Widest theme_count, bytes past the end of the record, no gaps at all.
        drain();
        write_theme_count(8'hff);
        no_gaps <= 1'b1;
        build_record(32'd254, NAME_DOTTED);
        seal_crc();
        send_record(RecBytes + 8);
        repeat (6) random_short_record(12);

        // Hold verdicts back while short records keep coming, so that input stalls.
        drain();
        no_gaps <= 1'b0;
        write_theme_count(8'($urandom_range(254, 2)));
        hold_kick <= ~hold_kick;
        repeat (8) random_short_record(4);

        drain();
        write_theme_count(8'h00);
        repeat (10) random_short_record(12);

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && waiting == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/srv_pkg.sv
rtl/srv_ident_check.sv
rtl/settings_record_validator.sv
bench/srv_checker.sv
bench/tb_top.sv
